// ----- rtl/core/ps2mpt_pkg.sv -----
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies; imported by every module of the block.
package ps2mpt_pkg;

    localparam int POSITION_WIDTH_DEFAULT = 16;

    // Reset values
    localparam int POS_X_RESET     = 40;
    localparam int POS_Y_RESET     = 25;
    localparam int COLUMNS_RESET   = 80;
    localparam int ROWS_RESET      = 50;

    // Grid limits
    localparam int COLUMNS_MAX     = 128;
    localparam int ROWS_MAX        = 64;

    // Flag byte bit positions
    localparam int FLAG_ALWAYS_ONE = 3;
    localparam int FLAG_X_SIGN     = 4;
    localparam int FLAG_Y_SIGN     = 5;
    localparam int FLAG_X_OVERFLOW = 6;
    localparam int FLAG_Y_OVERFLOW = 7;

    // Depth of the packet queue between framing and tracking
    localparam int QUEUE_DEPTH     = 4;

    localparam int APB_ADDR_WIDTH  = 3;

    typedef enum logic {
        REG_TEXT_COLUMNS = 1'b0,
        REG_TEXT_ROWS    = 1'b1
    } reg_index_t;

    // One framed packet
    typedef struct packed {
        logic [2:0] buttons;
        logic [8:0] delta_x;
        logic [8:0] delta_y;
    } packet_t;

endpackage

// ----- rtl/core/ps2mpt_front.sv -----
// Byte framing: collects flag, X and Y bytes into a packet record.
// Depends on ps2mpt_pkg.
module ps2mpt_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    output logic               push_valid,
    input  logic               push_ready,
    output ps2mpt_pkg::packet_t push_data
);
    import ps2mpt_pkg::*;

    typedef enum logic [1:0] {
        POS_FLAGS = 2'd0,
        POS_X     = 2'd1,
        POS_Y     = 2'd2
    } byte_pos_t;

    byte_pos_t   pos_reg, pos_next;
    logic [7:0]  flags_reg, flags_next;
    logic [8:0]  dx_reg, dx_next;
    logic [8:0]  dy_reg, dy_next;
    logic        take;

    // only the Y byte needs queue space
    assign s_ready = (pos_reg != POS_Y) || push_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        pos_next   = pos_reg;
        flags_next = flags_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        push_valid = 1'b0;
        if (take) begin
            unique case (pos_reg)
                POS_FLAGS: begin
                    // out-of-sync byte: stay at flag byte
                    if (s_data_byte[FLAG_ALWAYS_ONE]) begin
                        flags_next = s_data_byte;
                        pos_next   = POS_X;
                    end
                end
                POS_X: begin
                    if (!flags_reg[FLAG_X_OVERFLOW])
                        dx_next = {flags_reg[FLAG_X_SIGN], s_data_byte};
                    pos_next = POS_Y;
                end
                POS_Y: begin
                    if (!flags_reg[FLAG_Y_OVERFLOW])
                        dy_next = {flags_reg[FLAG_Y_SIGN], s_data_byte};
                    pos_next   = POS_FLAGS;
                    push_valid = 1'b1;
                end
                default: begin
                    pos_next = POS_FLAGS;
                end
            endcase
        end
    end

    assign push_data.buttons = flags_reg[2:0];
    assign push_data.delta_x = dx_reg;
    assign push_data.delta_y = dy_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_FLAGS;
            flags_reg <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
        end else begin
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
        end
    end

endmodule

// ----- rtl/core/ps2mpt_queue.sv -----
// Small packet queue between framing and position tracking.
// Depends on ps2mpt_pkg.
module ps2mpt_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  ps2mpt_pkg::packet_t wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output ps2mpt_pkg::packet_t rd_data
);
    import ps2mpt_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    packet_t         mem [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg, count_next;
    logic            do_wr, do_rd;

    assign wr_ready = (count_reg != (AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/core/ps2mpt_back.sv -----
// Position tracking pipeline: update, scale and clamp, buffer offset.
// Depends on ps2mpt_pkg.
module ps2mpt_back #(
    parameter int POSITION_WIDTH = ps2mpt_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          text_columns,
    input  logic [6:0]          text_rows,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  ps2mpt_pkg::packet_t pop_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_buttons,
    output logic signed [8:0]   m_delta_x,
    output logic signed [8:0]   m_delta_y,
    output logic [12:0]         m_pointer_x,
    output logic [12:0]         m_pointer_y,
    output logic [6:0]          m_cell_column,
    output logic [5:0]          m_cell_row,
    output logic [14:0]         m_buffer_offset
);
    import ps2mpt_pkg::*;

    localparam int W  = POSITION_WIDTH;
    localparam int PW = W - 2;
    localparam int EW = (PW > 13) ? PW : 13;

    logic          adv;

    // stage 1: positions
    logic [W-1:0]  pos_x_reg, pos_y_reg;
    logic          s1_valid_reg;
    packet_t       s1_pkt_reg;

    // stage 2: scaled and clamped
    logic          s2_valid_reg;
    packet_t       s2_pkt_reg;
    logic [12:0]   s2_px_reg, s2_py_reg;
    logic [6:0]    s2_col_reg;
    logic [5:0]    s2_row_reg;
    logic [7:0]    s2_cols_reg;

    logic [EW-1:0] px_wide, py_wide;
    logic [7:0]    cols_eff, col_full;
    logic [6:0]    rows_eff, row_full;
    logic [13:0]   cell_index;

    // whole pipe moves together; queue absorbs stalls
    assign adv       = !m_valid || m_ready;
    assign pop_ready = adv;

    // negative position divides toward zero to <= 0, then clamps to zero
    assign px_wide = pos_x_reg[W-1] ? '0 : EW'(pos_x_reg[W-1:2]);
    assign py_wide = pos_y_reg[W-1] ? '0 : EW'(pos_y_reg[W-1:2]);

    always_comb begin
        if (text_columns == '0)
            cols_eff = 8'd1;
        else if (text_columns > 8'(COLUMNS_MAX))
            cols_eff = 8'(COLUMNS_MAX);
        else
            cols_eff = text_columns;
        if (text_rows == '0)
            rows_eff = 7'd1;
        else if (text_rows > 7'(ROWS_MAX))
            rows_eff = 7'(ROWS_MAX);
        else
            rows_eff = text_rows;
    end

    assign col_full = (px_wide >= EW'(cols_eff)) ? cols_eff - 8'd1 : px_wide[7:0];
    assign row_full = (py_wide >= EW'(rows_eff)) ? rows_eff - 7'd1 : py_wide[6:0];

    assign cell_index = 14'(s2_row_reg) * 14'(s2_cols_reg) + 14'(s2_col_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_pkt_reg      <= pop_data;
            s2_pkt_reg      <= s1_pkt_reg;
            s2_px_reg       <= px_wide[12:0];
            s2_py_reg       <= py_wide[12:0];
            s2_col_reg      <= col_full[6:0];
            s2_row_reg      <= row_full[5:0];
            s2_cols_reg     <= cols_eff;
            m_buttons       <= s2_pkt_reg.buttons;
            m_delta_x       <= s2_pkt_reg.delta_x;
            m_delta_y       <= s2_pkt_reg.delta_y;
            m_pointer_x     <= s2_px_reg;
            m_pointer_y     <= s2_py_reg;
            m_cell_column   <= s2_col_reg;
            m_cell_row      <= s2_row_reg;
            m_buffer_offset <= {cell_index, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg    <= W'(POS_X_RESET);
            pos_y_reg    <= W'(POS_Y_RESET);
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid      <= 1'b0;
        end else if (adv) begin
            if (pop_valid) begin
                pos_x_reg <= pos_x_reg
                           + {{(W-9){pop_data.delta_x[8]}}, pop_data.delta_x};
                pos_y_reg <= pos_y_reg
                           - {{(W-9){pop_data.delta_y[8]}}, pop_data.delta_y};
            end
            s1_valid_reg <= pop_valid;
            s2_valid_reg <= s1_valid_reg;
            m_valid      <= s2_valid_reg;
        end
    end

endmodule

// ----- rtl/core/ps2_mouse_packet_tracker_core.sv -----
// PS/2 mouse packet tracker, top level with configuration registers.
// Depends on ps2mpt_pkg, ps2mpt_front, ps2mpt_queue, ps2mpt_back.
//
// Usage:
//   s_ channel: one mouse byte per transfer (valid/ready). Bytes are framed
//   into three-byte packets; a flag byte without bit 3 set is dropped.
//   m_ channel: one result per complete packet with buttons, deltas,
//   pointer position, text cell and text buffer offset.
//   APB port: register 0 text_columns at 0x0, register 1 text_rows at 0x4.
//   Write only while no packet is in flight.
// Throughput: one byte per cycle while s_ready is high. The framing stage needs queue
//   space only for the third byte of a packet.
// Path: after the third byte is transferred, the result passes through the
//   queue, position update stage, scale/clamp stage and output register.
// Reset: framing restarts at the flag byte, held deltas clear, position
//   returns to (40, 25), grid returns to 80 x 50. No clearing pass.
// Stall: while m_ready is low the tracking pipeline holds; the 4-entry
//   packet queue fills, and once full the third byte of a packet waits.
module ps2_mouse_packet_tracker_core #(
    parameter int POSITION_WIDTH = ps2mpt_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [7:0]                            s_data_byte,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [2:0]                            m_buttons,
    output logic signed [8:0]                     m_delta_x,
    output logic signed [8:0]                     m_delta_y,
    output logic [12:0]                           m_pointer_x,
    output logic [12:0]                           m_pointer_y,
    output logic [6:0]                            m_cell_column,
    output logic [5:0]                            m_cell_row,
    output logic [14:0]                           m_buffer_offset,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ps2mpt_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import ps2mpt_pkg::*;

    logic [7:0]  columns_reg;
    logic [6:0]  rows_reg;
    reg_index_t  reg_sel;
    logic        cfg_wr;

    logic        push_valid, push_ready;
    packet_t     push_data;
    logic        pop_valid, pop_ready;
    packet_t     pop_data;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_sel)
            REG_TEXT_COLUMNS: prdata = {24'd0, columns_reg};
            REG_TEXT_ROWS:    prdata = {25'd0, rows_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= 8'(COLUMNS_RESET);
            rows_reg    <= 7'(ROWS_RESET);
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_TEXT_COLUMNS: columns_reg <= pwdata[7:0];
                REG_TEXT_ROWS:    rows_reg    <= pwdata[6:0];
                default:          ;
            endcase
        end
    end

    ps2mpt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    ps2mpt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    ps2mpt_back #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .text_columns    (columns_reg),
        .text_rows       (rows_reg),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_data        (pop_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_buttons       (m_buttons),
        .m_delta_x       (m_delta_x),
        .m_delta_y       (m_delta_y),
        .m_pointer_x     (m_pointer_x),
        .m_pointer_y     (m_pointer_y),
        .m_cell_column   (m_cell_column),
        .m_cell_row      (m_cell_row),
        .m_buffer_offset (m_buffer_offset)
    );

endmodule
